>>> sv/i2cram_pkg.sv
// shared types and constants for the i2c register access master
// no dependencies; used by i2cram_core and i2c_register_access_master
`timescale 1ns / 1ps
`default_nettype none

package i2cram_pkg;

  // field widths of the transaction items
  localparam int KIND_W = 2;
  localparam int DEV_W  = 7;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int TPP_W  = 16;

  // configuration defaults
  localparam int              PHASE_COUNT_BITS_DEF = 16;
  localparam logic [TPP_W-1:0] TPP_RESET           = 16'd250;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_ADDR_NACK = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_REG_NACK  = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_DATA_NACK = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_RADR_NACK = 3'd4;

  // which byte is on the bus
  localparam logic [1:0] BYTE_ADDR_W = 2'd0;
  localparam logic [1:0] BYTE_REG    = 2'd1;
  localparam logic [1:0] BYTE_DATA   = 2'd2;
  localparam logic [1:0] BYTE_ADDR_R = 2'd3;

  // sequencer steps
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SA   = 4'd1;
  localparam logic [3:0] ST_SB   = 4'd2;
  localparam logic [3:0] ST_SC   = 4'd3;
  localparam logic [3:0] ST_TXL  = 4'd4;
  localparam logic [3:0] ST_TXH  = 4'd5;
  localparam logic [3:0] ST_AKL  = 4'd6;
  localparam logic [3:0] ST_AKH  = 4'd7;
  localparam logic [3:0] ST_RS   = 4'd8;
  localparam logic [3:0] ST_RXL  = 4'd9;
  localparam logic [3:0] ST_RXH  = 4'd10;
  localparam logic [3:0] ST_NKL  = 4'd11;
  localparam logic [3:0] ST_NKH  = 4'd12;
  localparam logic [3:0] ST_PA   = 4'd13;
  localparam logic [3:0] ST_PB   = 4'd14;
  localparam logic [3:0] ST_PC   = 4'd15;

  // one input tick
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  device_address;
    logic [BYTE_W-1:0] register_address;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;
  } tick_t;

  // one result item
  typedef struct packed {
    logic              scl_out;
    logic              sda_drive_low;
    logic              busy_res;
    logic              done_res;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

>>> sv/i2cram_core.sv
// bus sequencer: state registers and the per-tick next-state and output logic
// depends on i2cram_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cram_core #(
  parameter int PHASE_COUNT_BITS = i2cram_pkg::PHASE_COUNT_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              fire,
  input  wire  i2cram_pkg::tick_t          tick,
  input  wire  [i2cram_pkg::TPP_W-1:0]     ticks_per_phase,
  output i2cram_pkg::result_t              res
);

  localparam int LimW = (PHASE_COUNT_BITS > i2cram_pkg::TPP_W) ?
                        PHASE_COUNT_BITS : i2cram_pkg::TPP_W;

  // sequencer state
  logic [3:0]                        step_r, step_nxt;
  logic [PHASE_COUNT_BITS-1:0]       pcnt_r, pcnt_nxt;
  logic [2:0]                        bcnt_r, bcnt_nxt;
  logic [i2cram_pkg::BYTE_W-1:0]     shift_r, shift_nxt;
  logic [i2cram_pkg::DEV_W-1:0]      dev_r, dev_nxt;
  logic [i2cram_pkg::BYTE_W-1:0]     regad_r, regad_nxt;
  logic [i2cram_pkg::BYTE_W-1:0]     wdata_r, wdata_nxt;
  logic                              is_read_r, is_read_nxt;
  logic [i2cram_pkg::BYTE_W-1:0]     rdata_r, rdata_nxt;
  logic [i2cram_pkg::STAT_W-1:0]     stat_r, stat_nxt;
  logic [1:0]                        bidx_r, bidx_nxt;

  // phase length, clamped to one tick and to the counter range
  logic [LimW-1:0] tpp_ext, cmax_ext, limit;
  logic [LimW:0]   pcnt_inc;
  logic            phase_end;

  always_comb begin
    tpp_ext  = LimW'(ticks_per_phase);
    cmax_ext = LimW'({PHASE_COUNT_BITS{1'b1}});
    if (tpp_ext == '0) begin
      limit = LimW'(1);
    end else if (tpp_ext > cmax_ext) begin
      limit = cmax_ext;
    end else begin
      limit = tpp_ext;
    end
  end

  // byte to load for a given bus slot
  function automatic logic [7:0] byte_for(input logic [1:0] idx,
                                          input logic [6:0] dev,
                                          input logic [7:0] regad,
                                          input logic [7:0] wdata);
    logic [7:0] b;
    case (idx)
      i2cram_pkg::BYTE_ADDR_W: b = {dev, 1'b0};
      i2cram_pkg::BYTE_REG:    b = regad;
      i2cram_pkg::BYTE_DATA:   b = wdata;
      default:                 b = {dev, 1'b1};
    endcase
    return b;
  endfunction

  // status for a nack on a given byte
  function automatic logic [2:0] nack_status(input logic [1:0] idx);
    logic [2:0] s;
    case (idx)
      i2cram_pkg::BYTE_ADDR_W: s = i2cram_pkg::STATUS_ADDR_NACK;
      i2cram_pkg::BYTE_REG:    s = i2cram_pkg::STATUS_REG_NACK;
      i2cram_pkg::BYTE_DATA:   s = i2cram_pkg::STATUS_DATA_NACK;
      default:                 s = i2cram_pkg::STATUS_RADR_NACK;
    endcase
    return s;
  endfunction

  // request latch, bus drive and sequencer advance for one tick
  logic       busy, done, scl, sdl;
  logic [2:0] bcnt_inc;
  logic [7:0] rx_shift;

  always_comb begin
    step_nxt    = step_r;
    pcnt_nxt    = pcnt_r;
    bcnt_nxt    = bcnt_r;
    shift_nxt   = shift_r;
    dev_nxt     = dev_r;
    regad_nxt   = regad_r;
    wdata_nxt   = wdata_r;
    is_read_nxt = is_read_r;
    rdata_nxt   = rdata_r;
    stat_nxt    = stat_r;
    bidx_nxt    = bidx_r;
    done        = 1'b0;

    // take a request only when idle
    if (step_r == i2cram_pkg::ST_IDLE &&
        (tick.kind == i2cram_pkg::KIND_WRITE || tick.kind == i2cram_pkg::KIND_READ)) begin
      dev_nxt     = tick.device_address;
      regad_nxt   = tick.register_address;
      wdata_nxt   = tick.write_data;
      is_read_nxt = (tick.kind == i2cram_pkg::KIND_READ);
      stat_nxt    = i2cram_pkg::STATUS_OK;
      bidx_nxt    = i2cram_pkg::BYTE_ADDR_W;
      bcnt_nxt    = 3'd0;
      pcnt_nxt    = '0;
      step_nxt    = i2cram_pkg::ST_SA;
    end

    busy = (step_nxt != i2cram_pkg::ST_IDLE);

    // bus levels for the current step
    case (step_nxt)
      i2cram_pkg::ST_SA:  begin scl = 1'b1; sdl = 1'b0; end
      i2cram_pkg::ST_SB:  begin scl = 1'b1; sdl = 1'b1; end
      i2cram_pkg::ST_SC:  begin scl = 1'b0; sdl = 1'b1; end
      i2cram_pkg::ST_TXL: begin scl = 1'b0; sdl = ~shift_nxt[7]; end
      i2cram_pkg::ST_TXH: begin scl = 1'b1; sdl = ~shift_nxt[7]; end
      i2cram_pkg::ST_AKL, i2cram_pkg::ST_RS, i2cram_pkg::ST_RXL,
      i2cram_pkg::ST_NKL: begin scl = 1'b0; sdl = 1'b0; end
      i2cram_pkg::ST_AKH, i2cram_pkg::ST_RXH,
      i2cram_pkg::ST_NKH: begin scl = 1'b1; sdl = 1'b0; end
      i2cram_pkg::ST_PA:  begin scl = 1'b0; sdl = 1'b1; end
      i2cram_pkg::ST_PB:  begin scl = 1'b1; sdl = 1'b1; end
      default:            begin scl = 1'b1; sdl = 1'b0; end
    endcase

    // phase timer
    pcnt_inc  = (LimW+1)'(pcnt_nxt) + (LimW+1)'(1);
    phase_end = busy && (pcnt_inc >= {1'b0, limit});
    bcnt_inc  = bcnt_nxt + 3'd1;
    rx_shift  = {shift_nxt[6:0], tick.sda_in};

    if (busy && !phase_end) begin
      pcnt_nxt = pcnt_inc[PHASE_COUNT_BITS-1:0];
    end

    // step advance at the end of a phase
    if (phase_end) begin
      pcnt_nxt = '0;
      case (step_nxt)
        i2cram_pkg::ST_SA: step_nxt = i2cram_pkg::ST_SB;
        i2cram_pkg::ST_SB: step_nxt = i2cram_pkg::ST_SC;
        i2cram_pkg::ST_SC: begin
          shift_nxt = byte_for(bidx_nxt, dev_nxt, regad_nxt, wdata_nxt);
          bcnt_nxt  = 3'd0;
          step_nxt  = i2cram_pkg::ST_TXL;
        end
        i2cram_pkg::ST_TXL: step_nxt = i2cram_pkg::ST_TXH;
        i2cram_pkg::ST_TXH: begin
          shift_nxt = {shift_nxt[6:0], 1'b0};
          bcnt_nxt  = bcnt_inc;
          step_nxt  = (bcnt_inc == 3'd0) ? i2cram_pkg::ST_AKL : i2cram_pkg::ST_TXL;
        end
        i2cram_pkg::ST_AKL: step_nxt = i2cram_pkg::ST_AKH;
        i2cram_pkg::ST_AKH: begin
          if (tick.sda_in) begin
            stat_nxt = nack_status(bidx_nxt);
            step_nxt = i2cram_pkg::ST_PA;
          end else begin
            case (bidx_nxt)
              i2cram_pkg::BYTE_ADDR_W: begin
                bidx_nxt  = i2cram_pkg::BYTE_REG;
                shift_nxt = regad_nxt;
                bcnt_nxt  = 3'd0;
                step_nxt  = i2cram_pkg::ST_TXL;
              end
              i2cram_pkg::BYTE_REG: begin
                if (is_read_nxt) begin
                  bidx_nxt = i2cram_pkg::BYTE_ADDR_R;
                  step_nxt = i2cram_pkg::ST_RS;
                end else begin
                  bidx_nxt  = i2cram_pkg::BYTE_DATA;
                  shift_nxt = wdata_nxt;
                  bcnt_nxt  = 3'd0;
                  step_nxt  = i2cram_pkg::ST_TXL;
                end
              end
              i2cram_pkg::BYTE_DATA: step_nxt = i2cram_pkg::ST_PA;
              default: begin
                shift_nxt = 8'h00;
                bcnt_nxt  = 3'd0;
                step_nxt  = i2cram_pkg::ST_RXL;
              end
            endcase
          end
        end
        i2cram_pkg::ST_RS:  step_nxt = i2cram_pkg::ST_SA;
        i2cram_pkg::ST_RXL: step_nxt = i2cram_pkg::ST_RXH;
        i2cram_pkg::ST_RXH: begin
          shift_nxt = rx_shift;
          bcnt_nxt  = bcnt_inc;
          if (bcnt_inc == 3'd0) begin
            rdata_nxt = rx_shift;
            step_nxt  = i2cram_pkg::ST_NKL;
          end else begin
            step_nxt = i2cram_pkg::ST_RXL;
          end
        end
        i2cram_pkg::ST_NKL: step_nxt = i2cram_pkg::ST_NKH;
        i2cram_pkg::ST_NKH: step_nxt = i2cram_pkg::ST_PA;
        i2cram_pkg::ST_PA:  step_nxt = i2cram_pkg::ST_PB;
        i2cram_pkg::ST_PB:  step_nxt = i2cram_pkg::ST_PC;
        i2cram_pkg::ST_PC: begin
          step_nxt = i2cram_pkg::ST_IDLE;
          done     = 1'b1;
        end
        default: step_nxt = i2cram_pkg::ST_IDLE;
      endcase
    end

    res.scl_out       = scl;
    res.sda_drive_low = sdl;
    res.busy_res      = busy;
    res.done_res      = done;
    res.status        = stat_nxt;
    res.read_data     = rdata_nxt;
  end

  // state update on each processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= i2cram_pkg::ST_IDLE;
      pcnt_r    <= '0;
      bcnt_r    <= 3'd0;
      shift_r   <= 8'h00;
      dev_r     <= '0;
      regad_r   <= 8'h00;
      wdata_r   <= 8'h00;
      is_read_r <= 1'b0;
      rdata_r   <= 8'h00;
      stat_r    <= i2cram_pkg::STATUS_OK;
      bidx_r    <= i2cram_pkg::BYTE_ADDR_W;
    end else if (fire) begin
      step_r    <= step_nxt;
      pcnt_r    <= pcnt_nxt;
      bcnt_r    <= bcnt_nxt;
      shift_r   <= shift_nxt;
      dev_r     <= dev_nxt;
      regad_r   <= regad_nxt;
      wdata_r   <= wdata_nxt;
      is_read_r <= is_read_nxt;
      rdata_r   <= rdata_nxt;
      stat_r    <= stat_nxt;
      bidx_r    <= bidx_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/i2c_register_access_master.sv
// top level of the i2c register access master: input register, output register, config
// depends on i2cram_pkg and i2cram_core
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  kind, addresses, write data, sda sample
// out_      output     out_valid / out_stall scl, sda drive, busy, done, status, read data
// cfg_      input      cfg_wr_en            ticks_per_phase
//
// one tick transaction is accepted per cycle while in_stall is low; each yields exactly one result
// a tick is held in the input register, then passes through the sequencer logic into the output register
// the output register lets a new tick enter while a result waits to be taken
// reset (rst_n low, synchronous) returns the sequencer to idle and ticks_per_phase to 250
// a stalled output holds its result and stalls the input once the input register is full

module i2c_register_access_master #(
  parameter int PHASE_COUNT_BITS = i2cram_pkg::PHASE_COUNT_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // tick input
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_kind,
  input  wire  [6:0]  in_device_address,
  input  wire  [7:0]  in_register_address,
  input  wire  [7:0]  in_write_data,
  input  wire         in_sda_in,
  // result output
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_scl_out,
  output logic        out_sda_drive_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [7:0]  out_read_data,
  // configuration
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data
);

  logic                          in_v_r, in_v_nxt;
  i2cram_pkg::tick_t             tick_r;
  logic                          out_v_r, out_v_nxt;
  i2cram_pkg::result_t           res_r, res_c;
  logic [i2cram_pkg::TPP_W-1:0]  tpp_r;
  logic                          out_free, fire, in_take;

  // handshake control
  assign out_free = !out_v_r || !out_stall;
  assign fire     = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      tpp_r   <= i2cram_pkg::TPP_RESET;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_wr_en) begin
        tpp_r <= cfg_wr_data;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.kind             <= in_kind;
      tick_r.device_address   <= in_device_address;
      tick_r.register_address <= in_register_address;
      tick_r.write_data       <= in_write_data;
      tick_r.sda_in           <= in_sda_in;
    end
  end

  // bus sequencer
  i2cram_core #(
    .PHASE_COUNT_BITS(PHASE_COUNT_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .tick            (tick_r),
    .ticks_per_phase (tpp_r),
    .res             (res_c)
  );

  // output payload register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_c;
    end
  end

  assign out_valid         = out_v_r;
  assign out_scl_out       = res_r.scl_out;
  assign out_sda_drive_low = res_r.sda_drive_low;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;
  assign out_status        = res_r.status;
  assign out_read_data     = res_r.read_data;

endmodule

`default_nettype wire

>>> bench/i2c_register_access_master_tb.sv
// self-checking bench for i2c_register_access_master: directed table, random bus ticks, then a longest-phase run
// depends on i2cram_pkg and the i2c_register_access_master rtl, which also needs i2cram_core
`timescale 1ns / 1ps

module i2c_register_access_master_tb;

  localparam int PHASE_BITS = i2cram_pkg::PHASE_COUNT_BITS_DEF;
  localparam longint unsigned PHASE_MAX = (64'd1 << PHASE_BITS) - 64'd1;
  localparam logic [i2cram_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_TICKS_PER_PHASE = 120;
  localparam int LONG_RUN_TICKS = 120;
  localparam int DIR_ROWS = 9;
  localparam logic [15:0] SETTLE_PHASE_TICKS = 16'd1;

  // outputs on an idle bus and on the first start phase of a new request
  localparam i2cram_pkg::result_t RES_IDLE  =
    {1'b1, 1'b0, 1'b0, 1'b0, i2cram_pkg::STATUS_OK, 8'd0};
  localparam i2cram_pkg::result_t RES_START =
    {1'b1, 1'b0, 1'b1, 1'b0, i2cram_pkg::STATUS_OK, 8'd0};

  typedef struct packed {
    i2cram_pkg::tick_t   item;
    logic                typed;
    logic                settle;
    i2cram_pkg::result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = i2cram_pkg::KIND_TICK;
  logic [6:0] in_device_address = '0;
  logic [7:0] in_register_address = '0;
  logic [7:0] in_write_data = '0;
  logic in_sda_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_scl_out;
  logic out_sda_drive_low;
  logic out_busy_res;
  logic out_done_res;
  logic [2:0] out_status;
  logic [7:0] out_read_data;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  i2c_register_access_master dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_write_data       (in_write_data),
    .in_sda_in           (in_sda_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scl_out         (out_scl_out),
    .out_sda_drive_low   (out_sda_drive_low),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_status          (out_status),
    .out_read_data       (out_read_data),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // master sequencer as the bench sees it
  logic [3:0]      seq_step;
  longint unsigned phase_cnt;
  logic [2:0]      bit_cnt;
  logic [7:0]      shreg;
  logic [6:0]      lat_dev;
  logic [7:0]      lat_reg;
  logic [7:0]      lat_data;
  logic            rd_op;
  logic [7:0]      rd_byte;
  logic [2:0]      stat;
  logic [1:0]      byte_sel;
  logic [15:0]     phase_ticks;

  i2cram_pkg::result_t pending_levels [$];
  i2cram_pkg::result_t oldest_levels;
  int fail_count = 0;
  int burst_left = 0;
  logic [7:0] stall_window = '0;
  dir_row_t dir_rows [0:DIR_ROWS-1];

  function automatic void sequencer_reset();
    seq_step = i2cram_pkg::ST_IDLE;
    phase_cnt = 0;
    bit_cnt = '0;
    shreg = '0;
    lat_dev = '0;
    lat_reg = '0;
    lat_data = '0;
    rd_op = 1'b0;
    rd_byte = '0;
    stat = i2cram_pkg::STATUS_OK;
    byte_sel = i2cram_pkg::BYTE_ADDR_W;
    phase_ticks = i2cram_pkg::TPP_RESET;
  endfunction

  function automatic void load_tx_byte(input logic [1:0] sel);
    byte_sel = sel;
    case (sel)
      i2cram_pkg::BYTE_ADDR_W: shreg = {lat_dev, 1'b0};
      i2cram_pkg::BYTE_REG:    shreg = lat_reg;
      i2cram_pkg::BYTE_DATA:   shreg = lat_data;
      default:                 shreg = {lat_dev, 1'b1};
    endcase
    bit_cnt = '0;
    seq_step = i2cram_pkg::ST_TXL;
  endfunction

  // end of one bus phase; returns 1 when the final stop phase completes
  function automatic logic sequencer_advance(input logic sda);
    logic finished;
    finished = 1'b0;
    case (seq_step)
      i2cram_pkg::ST_SA:  seq_step = i2cram_pkg::ST_SB;
      i2cram_pkg::ST_SB:  seq_step = i2cram_pkg::ST_SC;
      i2cram_pkg::ST_SC:  load_tx_byte(byte_sel);
      i2cram_pkg::ST_TXL: seq_step = i2cram_pkg::ST_TXH;
      i2cram_pkg::ST_TXH: begin
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 3'd1;
        seq_step = (bit_cnt == 3'd0) ? i2cram_pkg::ST_AKL : i2cram_pkg::ST_TXL;
      end
      i2cram_pkg::ST_AKL: seq_step = i2cram_pkg::ST_AKH;
      i2cram_pkg::ST_AKH: begin
        if (sda) begin
          case (byte_sel)
            i2cram_pkg::BYTE_ADDR_W: stat = i2cram_pkg::STATUS_ADDR_NACK;
            i2cram_pkg::BYTE_REG:    stat = i2cram_pkg::STATUS_REG_NACK;
            i2cram_pkg::BYTE_DATA:   stat = i2cram_pkg::STATUS_DATA_NACK;
            default:                 stat = i2cram_pkg::STATUS_RADR_NACK;
          endcase
          seq_step = i2cram_pkg::ST_PA;
        end else if (byte_sel == i2cram_pkg::BYTE_ADDR_W) begin
          load_tx_byte(i2cram_pkg::BYTE_REG);
        end else if (byte_sel == i2cram_pkg::BYTE_REG) begin
          if (rd_op) begin
            byte_sel = i2cram_pkg::BYTE_ADDR_R;
            seq_step = i2cram_pkg::ST_RS;
          end else begin
            load_tx_byte(i2cram_pkg::BYTE_DATA);
          end
        end else if (byte_sel == i2cram_pkg::BYTE_DATA) begin
          seq_step = i2cram_pkg::ST_PA;
        end else begin
          shreg = '0;
          bit_cnt = '0;
          seq_step = i2cram_pkg::ST_RXL;
        end
      end
      i2cram_pkg::ST_RS:  seq_step = i2cram_pkg::ST_SA;
      i2cram_pkg::ST_RXL: seq_step = i2cram_pkg::ST_RXH;
      i2cram_pkg::ST_RXH: begin
        shreg = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt == 3'd0) begin
          rd_byte = shreg;
          seq_step = i2cram_pkg::ST_NKL;
        end else begin
          seq_step = i2cram_pkg::ST_RXL;
        end
      end
      i2cram_pkg::ST_NKL: seq_step = i2cram_pkg::ST_NKH;
      i2cram_pkg::ST_NKH: seq_step = i2cram_pkg::ST_PA;
      i2cram_pkg::ST_PA:  seq_step = i2cram_pkg::ST_PB;
      i2cram_pkg::ST_PB:  seq_step = i2cram_pkg::ST_PC;
      i2cram_pkg::ST_PC: begin
        seq_step = i2cram_pkg::ST_IDLE;
        finished = 1'b1;
      end
      default: seq_step = i2cram_pkg::ST_IDLE;
    endcase
    return finished;
  endfunction

  // bus levels and status for one tick, then move the sequencer on
  function automatic i2cram_pkg::result_t bus_tick(input i2cram_pkg::tick_t t);
    i2cram_pkg::result_t r;
    longint unsigned span;
    logic busy;
    logic finished;
    finished = 1'b0;
    if (seq_step == i2cram_pkg::ST_IDLE &&
        (t.kind == i2cram_pkg::KIND_WRITE || t.kind == i2cram_pkg::KIND_READ)) begin
      lat_dev = t.device_address;
      lat_reg = t.register_address;
      lat_data = t.write_data;
      rd_op = (t.kind == i2cram_pkg::KIND_READ);
      stat = i2cram_pkg::STATUS_OK;
      byte_sel = i2cram_pkg::BYTE_ADDR_W;
      bit_cnt = '0;
      phase_cnt = 0;
      seq_step = i2cram_pkg::ST_SA;
    end
    busy = (seq_step != i2cram_pkg::ST_IDLE);
    case (seq_step)
      i2cram_pkg::ST_SA:  {r.scl_out, r.sda_drive_low} = 2'b10;
      i2cram_pkg::ST_SB:  {r.scl_out, r.sda_drive_low} = 2'b11;
      i2cram_pkg::ST_SC:  {r.scl_out, r.sda_drive_low} = 2'b01;
      i2cram_pkg::ST_TXL: {r.scl_out, r.sda_drive_low} = {1'b0, ~shreg[7]};
      i2cram_pkg::ST_TXH: {r.scl_out, r.sda_drive_low} = {1'b1, ~shreg[7]};
      i2cram_pkg::ST_AKL, i2cram_pkg::ST_RS, i2cram_pkg::ST_RXL, i2cram_pkg::ST_NKL:
        {r.scl_out, r.sda_drive_low} = 2'b00;
      i2cram_pkg::ST_AKH, i2cram_pkg::ST_RXH, i2cram_pkg::ST_NKH:
        {r.scl_out, r.sda_drive_low} = 2'b10;
      i2cram_pkg::ST_PA:  {r.scl_out, r.sda_drive_low} = 2'b01;
      i2cram_pkg::ST_PB:  {r.scl_out, r.sda_drive_low} = 2'b11;
      default:            {r.scl_out, r.sda_drive_low} = 2'b10;
    endcase
    if (busy) begin
      // zero counts as one tick, anything past the counter saturates
      span = (phase_ticks == 16'd0) ? 64'd1 : 64'(phase_ticks);
      if (span > PHASE_MAX) span = PHASE_MAX;
      if (phase_cnt + 1 >= span) begin
        phase_cnt = 0;
        finished = sequencer_advance(t.sda_in);
      end else begin
        phase_cnt = (phase_cnt + 1) & PHASE_MAX;
      end
    end
    r.busy_res = busy;
    r.done_res = finished;
    r.status = stat;
    r.read_data = rd_byte;
    return r;
  endfunction

  // next tick: the target acks most slots and returns random read bits
  function automatic i2cram_pkg::tick_t next_tick(input bit may_request);
    i2cram_pkg::tick_t t;
    t.device_address = 7'($urandom_range(0, 127));
    t.register_address = 8'($urandom_range(0, 255));
    t.write_data = 8'($urandom_range(0, 255));
    if (seq_step == i2cram_pkg::ST_IDLE && may_request && $urandom_range(0, 2) == 0)
      t.kind = $urandom_range(0, 1) ? i2cram_pkg::KIND_READ : i2cram_pkg::KIND_WRITE;
    else if (seq_step == i2cram_pkg::ST_IDLE)
      t.kind = $urandom_range(0, 1) ? KIND_SPARE : i2cram_pkg::KIND_TICK;
    else
      t.kind = 2'($urandom_range(0, 3));
    if (seq_step == i2cram_pkg::ST_AKL || seq_step == i2cram_pkg::ST_AKH)
      t.sda_in = ($urandom_range(0, 15) == 0);
    else
      t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // present one tick in bursts with random gaps; predict once it is taken
  task automatic push_tick(input i2cram_pkg::tick_t t, input logic typed,
                           input i2cram_pkg::result_t want);
    int gap;
    i2cram_pkg::result_t model_res;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= t.kind;
    in_device_address <= t.device_address;
    in_register_address <= t.register_address;
    in_write_data <= t.write_data;
    in_sda_in <= t.sda_in;
    do @(posedge clk); while (in_stall !== 1'b0);
    model_res = bus_tick(t);
    pending_levels.push_back(typed ? want : model_res);
  endtask

  task automatic settle_to_idle();
    while (seq_step != i2cram_pkg::ST_IDLE) push_tick(next_tick(1'b0), 1'b0, RES_IDLE);
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    phase_ticks = value;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // receiver stalls at random, one window in four runs without stalls
  always @(posedge clk) begin
    stall_window <= stall_window + 8'd1;
    out_stall <= (stall_window[7:6] != 2'b00) && ($urandom_range(0, 3) == 0);
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_levels.size() == 0) begin
        $error("result arrived with no transaction waiting");
        fail_count++;
      end else begin
        oldest_levels = pending_levels.pop_front();
        check_field("scl_out", 8'(oldest_levels.scl_out), 8'(out_scl_out));
        check_field("sda_drive_low", 8'(oldest_levels.sda_drive_low), 8'(out_sda_drive_low));
        check_field("busy_res", 8'(oldest_levels.busy_res), 8'(out_busy_res));
        check_field("done_res", 8'(oldest_levels.done_res), 8'(out_done_res));
        check_field("status", 8'(oldest_levels.status), 8'(out_status));
        check_field("read_data", oldest_levels.read_data, out_read_data);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    logic [15:0] phase_list [0:4];
    i2cram_pkg::tick_t t;
    // directed rows at the reset phase length
    dir_rows[0] = {i2cram_pkg::KIND_TICK,  7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, RES_IDLE};
    dir_rows[1] = {i2cram_pkg::KIND_TICK,  7'h7f, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0, RES_IDLE};
    dir_rows[2] = {KIND_SPARE,             7'h7f, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0, RES_IDLE};
    dir_rows[3] = {i2cram_pkg::KIND_WRITE, 7'h7f, 8'hff, 8'hff, 1'b0, 1'b1, 1'b0, RES_START};
    dir_rows[4] = {i2cram_pkg::KIND_READ,  7'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, RES_START};
    dir_rows[5] = {KIND_SPARE,             7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, RES_IDLE};
    dir_rows[6] = {i2cram_pkg::KIND_WRITE, 7'h2a, 8'h55, 8'haa, 1'b1, 1'b0, 1'b1, RES_IDLE};
    dir_rows[7] = {i2cram_pkg::KIND_READ,  7'h7f, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, RES_START};
    dir_rows[8] = {i2cram_pkg::KIND_TICK,  7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, RES_IDLE};
    phase_list[0] = 16'd1;
    phase_list[1] = 16'd0;
    phase_list[2] = 16'd2;
    phase_list[3] = 16'd3;
    phase_list[4] = 16'd5;
    sequencer_reset();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // a settling row finishes its transaction at the shortest phase length
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_tick(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].settle) begin
        wait_results();
        set_phase_ticks(SETTLE_PHASE_TICKS);
        settle_to_idle();
        wait_results();
        set_phase_ticks(i2cram_pkg::TPP_RESET);
      end
    end
    wait_results();

    // random traffic over short phase lengths, both extremes of the low end
    foreach (phase_list[p]) begin
      set_phase_ticks(phase_list[p]);
      repeat (RANDOM_TICKS_PER_PHASE) push_tick(next_tick(1'b1), 1'b0, RES_IDLE);
      settle_to_idle();
      wait_results();
    end

    // longest phase length: one request held in its first start phase
    set_phase_ticks(16'hffff);
    t = next_tick(1'b0);
    t.kind = i2cram_pkg::KIND_READ;
    push_tick(t, 1'b0, RES_IDLE);
    repeat (LONG_RUN_TICKS) push_tick(next_tick(1'b0), 1'b0, RES_IDLE);
    wait_results();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> i2c_register_access_master.f
sv/i2cram_pkg.sv
sv/i2cram_core.sv
sv/i2c_register_access_master.sv
bench/i2c_register_access_master_tb.sv
